@@ rtl/core/bfd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfd_pkg
// Shared types and constants for the box filter downscaler.
// ----------------------------------------------------------------------------
package bfd_pkg;

	// Default sizing handed to the top level
	localparam int DEF_MAX_OUT_WIDTH = 1024;
	localparam int DEF_MAX_BLOCK     = 8;

	// Pixel format
	localparam int CHANNELS = 4;
	localparam int PIX_W    = 8;

	// Output height handling
	localparam int OUT_HEIGHT_LIMIT = 1024;
	localparam int ROW_W            = 10;

	// Configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 11;
	localparam int CFG_BS_W   = 4;

	localparam int BLOCK_SIZE_RST = 2;
	localparam int OUT_WIDTH_RST  = 1;
	localparam int OUT_HEIGHT_RST = 1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_BLOCK_SIZE = 2'd0,
		CFG_OUT_WIDTH  = 2'd1,
		CFG_OUT_HEIGHT = 2'd2
	} cfg_reg_t;

	// Result buffer
	localparam int OUT_FIFO_DEPTH = 8;
	localparam int OFIFO_PTR_W    = $clog2(OUT_FIFO_DEPTH);
	localparam int OFIFO_CNT_W    = $clog2(OUT_FIFO_DEPTH + 1);

	// Frame position marks travelling with a block result
	typedef struct packed {
		logic frame_end;
		logic row_end;
	} out_flags_t;

	// One finished output word
	typedef struct packed {
		out_flags_t                      flags;
		logic [CHANNELS-1:0][PIX_W-1:0] pix;
	} res_word_t;

endpackage

@@ rtl/core/bfd_accum.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfd_accum
// Raster position counters and the column-sum memory. Each accepted pixel
// reads its column's sums, adds itself and writes back, a block's first pixel
// overwriting; back-to-back hits on one column forward the last written value.
// ----------------------------------------------------------------------------
module bfd_accum
	import bfd_pkg::*;
#(
	parameter int MAX_OUT_WIDTH = DEF_MAX_OUT_WIDTH,
	parameter int MAX_BLOCK     = DEF_MAX_BLOCK,
	localparam int NB = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1,
	localparam int NW = $clog2(MAX_BLOCK + 1),
	localparam int AW = (MAX_OUT_WIDTH > 1) ? $clog2(MAX_OUT_WIDTH) : 1,
	localparam int WW = $clog2(MAX_OUT_WIDTH + 1),
	localparam int SW = PIX_W + $clog2(MAX_BLOCK * MAX_BLOCK)
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             restart,
	input  logic [NW-1:0]                    n,
	input  logic [WW-1:0]                    w,
	input  logic [CFG_DATA_W-1:0]            h,
	input  logic                             px_valid,
	input  logic [CHANNELS-1:0][PIX_W-1:0]   px,
	output logic                             cur_last,
	output logic                             sum_valid,
	output logic [CHANNELS-1:0][SW-1:0]      sums,
	output out_flags_t                       sum_flags
);

	logic [NB-1:0]    sub_col_q;
	logic [NB-1:0]    sub_row_q;
	logic [AW-1:0]    col_q;
	logic [ROW_W-1:0] row_q;

	logic sc_wrap, sr_wrap, cc_wrap, rr_wrap, cur_first;

	// Position decode
	always_comb begin
		sc_wrap   = (NW'(sub_col_q) + NW'(1)) >= n;
		sr_wrap   = (NW'(sub_row_q) + NW'(1)) >= n;
		cc_wrap   = (WW'(col_q) + WW'(1)) >= w;
		rr_wrap   = (CFG_DATA_W'(row_q) + CFG_DATA_W'(1)) >= h;
		cur_first = (sub_row_q == '0) && (sub_col_q == '0);
		cur_last  = sr_wrap && sc_wrap;
	end

	// Raster counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sub_col_q <= '0;
			sub_row_q <= '0;
			col_q     <= '0;
			row_q     <= '0;
		end else if (restart) begin
			sub_col_q <= '0;
			sub_row_q <= '0;
			col_q     <= '0;
			row_q     <= '0;
		end else if (px_valid) begin
			if (!sc_wrap) begin
				sub_col_q <= sub_col_q + NB'(1);
			end else begin
				sub_col_q <= '0;
				if (!cc_wrap) begin
					col_q <= col_q + AW'(1);
				end else begin
					col_q <= '0;
					if (!sr_wrap) begin
						sub_row_q <= sub_row_q + NB'(1);
					end else begin
						sub_row_q <= '0;
						row_q     <= rr_wrap ? '0 : row_q + ROW_W'(1);
					end
				end
			end
		end
	end

	// Stage 1 control
	logic                            valid_s1;
	logic                            fwd_s1;
	logic [AW-1:0]                   col_s1;
	logic [CHANNELS-1:0][PIX_W-1:0]  px_s1;
	logic                            first_s1;
	logic                            last_s1;
	out_flags_t                      flags_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			fwd_s1   <= 1'b0;
		end else begin
			valid_s1 <= px_valid;
			// the word in stage 1 writes this column at the same edge as the read
			fwd_s1   <= valid_s1 && (col_s1 == col_q);
		end
	end

	always_ff @(posedge clk) begin
		if (px_valid) begin
			col_s1             <= col_q;
			px_s1              <= px;
			first_s1           <= cur_first;
			last_s1            <= cur_last;
			flags_s1.row_end   <= cc_wrap;
			flags_s1.frame_end <= cc_wrap && rr_wrap;
		end
	end

	// Column-sum memory, one row per output column
	logic [CHANNELS-1:0][SW-1:0] mem [MAX_OUT_WIDTH];
	logic [CHANNELS-1:0][SW-1:0] rd_s1;
	logic [CHANNELS-1:0][SW-1:0] wsum_q;
	logic [CHANNELS-1:0][SW-1:0] new_sum;

	always_ff @(posedge clk) begin
		rd_s1 <= mem[col_q];
	end

	// Accumulate: first pixel of a block overwrites the column's sums
	always_comb begin
		for (int c = 0; c < CHANNELS; c++) begin
			if (first_s1) begin
				new_sum[c] = SW'(px_s1[c]);
			end else if (fwd_s1) begin
				new_sum[c] = wsum_q[c] + SW'(px_s1[c]);
			end else begin
				new_sum[c] = rd_s1[c] + SW'(px_s1[c]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			mem[col_s1] <= new_sum;
			wsum_q      <= new_sum;
		end
	end

	// Stage 2: completed block sums
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_valid <= 1'b0;
		end else begin
			sum_valid <= valid_s1 && last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && last_s1) begin
			sums      <= new_sum;
			sum_flags <= flags_s1;
		end
	end

	// Checks
	a_restart_clears: assert property (@(posedge clk) disable iff (!arst_n)
		restart |=> (sub_col_q == '0) && (sub_row_q == '0) && (col_q == '0) && (row_q == '0))
		else $error("position counters not cleared after config write");

	a_sub_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(NW'(sub_col_q) < n) && (NW'(sub_row_q) < n))
		else $error("sub-block counter outside block size");

	a_col_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(WW'(col_q) < w) && (CFG_DATA_W'(row_q) < h))
		else $error("output column or row outside image");

endmodule

@@ rtl/core/bfd_mean.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfd_mean
// Rounded block mean per channel: (2*sum + N*N) / (2*N*N), done as a
// multiply by a per-N reciprocal from a constant table, then a shift.
// ----------------------------------------------------------------------------
module bfd_mean
	import bfd_pkg::*;
#(
	parameter int MAX_BLOCK = DEF_MAX_BLOCK,
	localparam int NB  = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1,
	localparam int NW  = $clog2(MAX_BLOCK + 1),
	localparam int SW  = PIX_W + $clog2(MAX_BLOCK * MAX_BLOCK),
	localparam int XW  = SW + 1,
	localparam int ARW = $clog2(MAX_BLOCK * MAX_BLOCK + 1),
	localparam int K   = XW + $clog2(2 * MAX_BLOCK * MAX_BLOCK),
	localparam int PW  = XW + K
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [NW-1:0]                   n,
	input  logic                            in_valid,
	input  logic [CHANNELS-1:0][SW-1:0]     sums,
	input  out_flags_t                      in_flags,
	output logic                            out_valid,
	output res_word_t                       out_word
);

	// Area and reciprocal tables, one entry per block size
	logic [ARW-1:0] area_tab  [MAX_BLOCK];
	logic [K-1:0]   recip_tab [MAX_BLOCK];

	for (genvar i = 1; i <= MAX_BLOCK; i++) begin : g_tab
		localparam longint unsigned AREA = longint'(i) * longint'(i);
		localparam longint unsigned DIVR = 2 * AREA;
		localparam longint unsigned RCP  = ((64'd1 << K) + DIVR - 1) / DIVR;
		assign area_tab[i-1]  = ARW'(AREA);
		assign recip_tab[i-1] = K'(RCP);
	end

	logic [NW-1:0] n_m1;
	assign n_m1 = n - NW'(1);

	// Stage 1: rounding numerator and reciprocal
	logic                         valid_s1;
	logic [CHANNELS-1:0][XW-1:0]  x_s1;
	logic [K-1:0]                 recip_s1;
	out_flags_t                   flags_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid) begin
			for (int c = 0; c < CHANNELS; c++) begin
				x_s1[c] <= {sums[c], 1'b0} + XW'(area_tab[n_m1[NB-1:0]]);
			end
			recip_s1 <= recip_tab[n_m1[NB-1:0]];
			flags_s1 <= in_flags;
		end
	end

	// Stage 2: reciprocal multiply
	logic                         valid_s2;
	logic [CHANNELS-1:0][PW-1:0]  prod_s2;
	out_flags_t                   flags_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			for (int c = 0; c < CHANNELS; c++) begin
				prod_s2[c] <= PW'(x_s1[c]) * PW'(recip_s1);
			end
			flags_s2 <= flags_s1;
		end
	end

	// Quotient is the product shifted down by K
	always_comb begin
		out_valid      = valid_s2;
		out_word.flags = flags_s2;
		for (int c = 0; c < CHANNELS; c++) begin
			out_word.pix[c] = prod_s2[c][K +: PIX_W];
		end
	end

	// Checks
	a_n_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid |-> (n != '0) && (32'(n) <= MAX_BLOCK))
		else $error("block size outside table");

	a_pipe_follow: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid |-> ##2 out_valid)
		else $error("mean pipeline dropped a word");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> $past(in_valid, 2))
		else $error("mean pipeline produced a word from nothing");

endmodule

@@ rtl/core/bfd_out_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfd_out_fifo
// Small result buffer between the mean pipeline and the output stream.
// ----------------------------------------------------------------------------
module bfd_out_fifo
	import bfd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       wr_en,
	input  res_word_t  wr_word,
	input  logic       rd_en,
	output logic       not_empty,
	output res_word_t  rd_word
);

	res_word_t              buf_q [OUT_FIFO_DEPTH];
	logic [OFIFO_PTR_W-1:0] wr_ptr_q;
	logic [OFIFO_PTR_W-1:0] rd_ptr_q;
	logic [OFIFO_CNT_W-1:0] count_q;

	// Storage
	always_ff @(posedge clk) begin
		if (wr_en) begin
			buf_q[wr_ptr_q] <= wr_word;
		end
	end

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + OFIFO_PTR_W'(1);
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + OFIFO_PTR_W'(1);
			end
			case ({wr_en, rd_en})
				2'b10:   count_q <= count_q + OFIFO_CNT_W'(1);
				2'b01:   count_q <= count_q - OFIFO_CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	assign not_empty = (count_q != '0);
	assign rd_word   = buf_q[rd_ptr_q];

	// Checks
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en && !rd_en |-> count_q != OFIFO_CNT_W'(OUT_FIFO_DEPTH))
		else $error("result buffer overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> count_q != '0)
		else $error("result buffer underflow");

	a_ptr_track: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) || (count_q == OFIFO_CNT_W'(OUT_FIFO_DEPTH)) ||
		(wr_ptr_q != rd_ptr_q))
		else $error("buffer pointers disagree with fill level");

endmodule

@@ rtl/core/box_filter_downscale_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_filter_downscale_top
// Integer-factor RGBA box filter downscaler with configurable output size.
// ----------------------------------------------------------------------------
//  channel  | dir | word contents
//  s_axis   | in  | one source pixel, raster order: red, green, blue, alpha
//  m_axis   | out | one block mean pixel; tlast = end of row, tuser = end of frame
//  cfg      | in  | register write: block size, output width, output height
//
//  While tready is high one source pixel is taken per clock; the column-sum
//  memory does one read-modify-write per pixel, forwarding across consecutive
//  pixels of one block. Results pass the accumulator, mean and output buffer.
//  tready drops only while eight results are owed to the output side.
//  No clearing pass after reset: a block's first pixel overwrites its sums.
//  Writing block size, width or height resets the raster position to frame start.
// ----------------------------------------------------------------------------
module box_filter_downscale_top
	import bfd_pkg::*;
#(
	parameter int MAX_OUT_WIDTH = DEF_MAX_OUT_WIDTH,
	parameter int MAX_BLOCK     = DEF_MAX_BLOCK
) (
	input  logic                      clk,
	input  logic                      arst_n,
	// configuration writes
	input  logic                      cfg_we,
	input  logic [CFG_IDX_W-1:0]      cfg_index,
	input  logic [CFG_DATA_W-1:0]     cfg_data,
	// source pixels
	input  logic                      s_axis_tvalid,
	output logic                      s_axis_tready,
	input  logic [31:0]               s_axis_tdata,   // red, green, blue, alpha
	// downscaled pixels
	output logic                      m_axis_tvalid,
	input  logic                      m_axis_tready,
	output logic [31:0]               m_axis_tdata,   // red, green, blue, alpha
	output logic                      m_axis_tlast,   // row_end
	output logic [0:0]                m_axis_tuser    // frame_end
);

	localparam int NW = $clog2(MAX_BLOCK + 1);
	localparam int WW = $clog2(MAX_OUT_WIDTH + 1);
	localparam int SW = PIX_W + $clog2(MAX_BLOCK * MAX_BLOCK);
	localparam int N_RST = (BLOCK_SIZE_RST > MAX_BLOCK) ? MAX_BLOCK : BLOCK_SIZE_RST;
	localparam int W_RST = (OUT_WIDTH_RST > MAX_OUT_WIDTH) ? MAX_OUT_WIDTH : OUT_WIDTH_RST;

	// Configuration registers, held already clamped
	logic [NW-1:0]         n_q;
	logic [WW-1:0]         w_q;
	logic [CFG_DATA_W-1:0] h_q;
	logic                  restart;
	logic [CFG_BS_W-1:0]   bs_raw;

	assign bs_raw = cfg_data[CFG_BS_W-1:0];

	always_comb begin
		unique case (cfg_index) inside
			CFG_BLOCK_SIZE, CFG_OUT_WIDTH, CFG_OUT_HEIGHT: restart = cfg_we;
			default:                                       restart = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q <= NW'(N_RST);
			w_q <= WW'(W_RST);
			h_q <= CFG_DATA_W'(OUT_HEIGHT_RST);
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_BLOCK_SIZE: begin
					if (bs_raw == '0) begin
						n_q <= NW'(1);
					end else if (32'(bs_raw) > MAX_BLOCK) begin
						n_q <= NW'(MAX_BLOCK);
					end else begin
						n_q <= NW'(bs_raw);
					end
				end
				CFG_OUT_WIDTH: begin
					if (cfg_data == '0) begin
						w_q <= WW'(1);
					end else if (32'(cfg_data) > MAX_OUT_WIDTH) begin
						w_q <= WW'(MAX_OUT_WIDTH);
					end else begin
						w_q <= WW'(cfg_data);
					end
				end
				CFG_OUT_HEIGHT: begin
					if (cfg_data == '0) begin
						h_q <= CFG_DATA_W'(1);
					end else if (32'(cfg_data) > OUT_HEIGHT_LIMIT) begin
						h_q <= CFG_DATA_W'(OUT_HEIGHT_LIMIT);
					end else begin
						h_q <= cfg_data;
					end
				end
				default: begin
					n_q <= n_q;
				end
			endcase
		end
	end

	// Credit: results owed to the output side
	logic                   in_acc;
	logic                   out_acc;
	logic                   cur_last;
	logic [OFIFO_CNT_W-1:0] pending_q;
	logic                   owe;

	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign out_acc       = m_axis_tvalid && m_axis_tready;
	assign owe           = in_acc && cur_last;
	assign s_axis_tready = pending_q < OFIFO_CNT_W'(OUT_FIFO_DEPTH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else begin
			case ({owe, out_acc})
				2'b10:   pending_q <= pending_q + OFIFO_CNT_W'(1);
				2'b01:   pending_q <= pending_q - OFIFO_CNT_W'(1);
				default: pending_q <= pending_q;
			endcase
		end
	end

	// Accumulation over the column-sum memory
	logic                          sum_valid;
	logic [CHANNELS-1:0][SW-1:0]   sums;
	out_flags_t                    sum_flags;

	bfd_accum #(
		.MAX_OUT_WIDTH (MAX_OUT_WIDTH),
		.MAX_BLOCK     (MAX_BLOCK)
	) u_accum (
		.clk       (clk),
		.arst_n    (arst_n),
		.restart   (restart),
		.n         (n_q),
		.w         (w_q),
		.h         (h_q),
		.px_valid  (in_acc),
		.px        (s_axis_tdata),
		.cur_last  (cur_last),
		.sum_valid (sum_valid),
		.sums      (sums),
		.sum_flags (sum_flags)
	);

	// Block mean
	logic      res_valid;
	res_word_t res_word;

	bfd_mean #(
		.MAX_BLOCK (MAX_BLOCK)
	) u_mean (
		.clk       (clk),
		.arst_n    (arst_n),
		.n         (n_q),
		.in_valid  (sum_valid),
		.sums      (sums),
		.in_flags  (sum_flags),
		.out_valid (res_valid),
		.out_word  (res_word)
	);

	// Output buffer
	res_word_t head_word;

	bfd_out_fifo u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (res_valid),
		.wr_word   (res_word),
		.rd_en     (out_acc),
		.not_empty (m_axis_tvalid),
		.rd_word   (head_word)
	);

	assign m_axis_tdata    = head_word.pix;
	assign m_axis_tlast    = head_word.flags.row_end;
	assign m_axis_tuser[0] = head_word.flags.frame_end;

	// Checks
	a_credit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q <= OFIFO_CNT_W'(OUT_FIFO_DEPTH))
		else $error("owed result count above buffer depth");

	a_out_owed: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> pending_q != '0)
		else $error("output word not covered by a credit");

	a_res_owed: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> pending_q != '0)
		else $error("mean result not covered by a credit");

endmodule

@@ test/tb_box_filter_downscale_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_box_filter_downscale_top
// Self-checking bench for the RGBA box filter downscaler.
// ----------------------------------------------------------------------------
// Source pixels are queued by the stimulus process and sent by a clocked
// driver with random gaps. A clocked monitor applies random back-pressure
// and checks each block mean word against a local model of the column sums
// and raster counters. Registers are rewritten between phases while the
// block is idle, covering the reset setting, saturated and zero sizes,
// mid-frame restarts and the unused register index.
// ----------------------------------------------------------------------------
module tb_box_filter_downscale_top;
	import bfd_pkg::*;

	localparam int MAX_COLS     = DEF_MAX_OUT_WIDTH;
	localparam int RAND_PIXELS  = 1000;
	localparam int STALL_LIMIT  = 4000;
	localparam int DRAIN_CYCLES = 12;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

	typedef logic [CHANNELS-1:0][PIX_W-1:0] pixel_t;

	logic                  clk           = 1'b0;
	logic                  arst_n        = 1'b0;
	logic                  cfg_we        = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index     = '0;
	logic [CFG_DATA_W-1:0] cfg_data      = '0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [31:0]           s_axis_tdata  = '0;   // red, green, blue, alpha
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [31:0]           m_axis_tdata;         // red, green, blue, alpha
	logic                  m_axis_tlast;         // row_end
	logic [0:0]            m_axis_tuser;         // frame_end

	box_filter_downscale_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

	always #5 clk = ~clk;

	// Stimulus and expectation stores
	pixel_t    pixel_q[$];
	res_word_t mean_q[$];
	int        pixels_owed = 0;
	int        errors      = 0;
	bit        quiet_phase = 1'b0;
	string     chan_name [CHANNELS] = '{"red", "green", "blue", "alpha"};

	// Model registers and state
	logic [CFG_BS_W-1:0]   blk_reg = CFG_BS_W'(BLOCK_SIZE_RST);
	logic [CFG_DATA_W-1:0] wid_reg = CFG_DATA_W'(OUT_WIDTH_RST);
	logic [CFG_DATA_W-1:0] hgt_reg = CFG_DATA_W'(OUT_HEIGHT_RST);
	logic [13:0] col_sum [CHANNELS][MAX_COLS];
	int sub_col = 0, out_col = 0, sub_row = 0, out_row = 0;

	function automatic int clamp_to(int v, int hi);
		if (v < 1) return 1;
		if (v > hi) return hi;
		return v;
	endfunction

	function automatic int eff_block();
		return clamp_to(int'(blk_reg), DEF_MAX_BLOCK);
	endfunction

	function automatic int eff_width();
		return clamp_to(int'(wid_reg), MAX_COLS);
	endfunction

	function automatic int eff_height();
		return clamp_to(int'(hgt_reg), OUT_HEIGHT_LIMIT);
	endfunction

	// Accumulate one source pixel; queue a block mean when the block closes
	function automatic void accumulate_pixel(pixel_t p);
		int n, w, h, col, area;
		bit opens, closes;
		res_word_t r;
		n = eff_block();
		w = eff_width();
		h = eff_height();
		col = (out_col >= MAX_COLS) ? MAX_COLS - 1 : out_col;
		opens = (sub_row == 0) && (sub_col == 0);
		for (int c = 0; c < CHANNELS; c++)
			col_sum[c][col] = opens ? 14'(p[c]) : col_sum[c][col] + 14'(p[c]);
		closes = (sub_row + 1 >= n) && (sub_col + 1 >= n);
		if (closes) begin
			area = n * n;
			for (int c = 0; c < CHANNELS; c++)
				r.pix[c] = PIX_W'((2 * int'(col_sum[c][col]) + area) / (2 * area));
			r.flags.row_end   = (out_col + 1 >= w);
			r.flags.frame_end = r.flags.row_end && (out_row + 1 >= h);
			mean_q.push_back(r);
		end
		// advance raster position
		sub_col++;
		if (sub_col >= n) begin
			sub_col = 0;
			out_col++;
			if (out_col >= w) begin
				out_col = 0;
				sub_row++;
				if (sub_row >= n) begin
					sub_row = 0;
					out_row++;
					if (out_row >= h) out_row = 0;
				end
			end
		end
	endfunction

	function automatic int pick_gap();
		int r;
		if (quiet_phase) return 0;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic pixel_t rand_pixel();
		pixel_t p;
		for (int c = 0; c < CHANNELS; c++) begin
			case ($urandom_range(0, 7))
				0: p[c] = 8'h00;
				1: p[c] = 8'hFF;
				default: p[c] = PIX_W'($urandom_range(0, 255));
			endcase
		end
		return p;
	endfunction

	function automatic void check_field(string name, int want, int got);
		if (want != got) begin
			$display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			errors++;
		end
	endfunction

	// Source driver
	int send_gap = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			send_gap      <= 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				accumulate_pixel(pixel_t'(s_axis_tdata));
				pixels_owed--;
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (send_gap > 0) begin
					send_gap      <= send_gap - 1;
					s_axis_tvalid <= 1'b0;
				end else if (pixel_q.size() > 0) begin
					s_axis_tvalid <= 1'b1;
					s_axis_tdata  <= pixel_q.pop_front();
					send_gap      <= pick_gap();
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// Result monitor with random back-pressure
	int        ready_gap = 0;
	res_word_t want;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			ready_gap     <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (mean_q.size() == 0) begin
					$display("%0t ns: unexpected word, expected none, actual %h last %b user %b",
						$time, m_axis_tdata, m_axis_tlast, m_axis_tuser);
					errors++;
				end else begin
					want = mean_q.pop_front();
					for (int c = 0; c < CHANNELS; c++)
						check_field(chan_name[c], want.pix[c], m_axis_tdata[c*PIX_W +: PIX_W]);
					check_field("row_end", want.flags.row_end, m_axis_tlast);
					check_field("frame_end", want.flags.frame_end, m_axis_tuser[0]);
				end
			end
			if (ready_gap > 0) begin
				ready_gap     <= ready_gap - 1;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
				if ($urandom_range(0, 5) == 0) ready_gap <= pick_gap();
			end
		end
	end

	// Watchdog on cycles without any accepted word
	int stall_cycles = 0;
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("box_filter_downscale_top verification failed");
			$finish;
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		// mirror the register and the frame restart
		if (idx != CFG_SPARE) begin
			if (idx == CFG_BLOCK_SIZE) blk_reg = val[CFG_BS_W-1:0];
			else if (idx == CFG_OUT_WIDTH) wid_reg = val;
			else hgt_reg = val;
			sub_col = 0;
			out_col = 0;
			sub_row = 0;
			out_row = 0;
		end
	endtask

	task automatic queue_pixel(input pixel_t p);
		pixels_owed++;
		pixel_q.push_back(p);
	endtask

	task automatic queue_random(input int count);
		repeat (count) queue_pixel(rand_pixel());
	endtask

	// Wait until every pixel is taken and every mean has come back
	task automatic wait_drained();
		while (pixels_owed != 0 || mean_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	int rand_sent;
	int frame_px;
	int count;

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Reset setting 2x2 blocks, one output: extremes and half rounding
		queue_pixel({8'h01, 8'h01, 8'h00, 8'hFF});
		queue_pixel({8'h00, 8'h01, 8'h00, 8'hFF});
		queue_pixel({8'h00, 8'h00, 8'h00, 8'hFF});
		queue_pixel({8'h00, 8'h00, 8'h00, 8'hFF});
		// next frame after wrap
		queue_pixel({8'hFF, 8'h00, 8'hFF, 8'h00});
		queue_pixel({8'hFF, 8'h00, 8'hFF, 8'h00});
		queue_pixel({8'hFE, 8'h01, 8'h01, 8'hFE});
		queue_pixel({8'hFF, 8'h00, 8'hFF, 8'h00});
		wait_drained();

		// Block size zero (upper data bits masked off): pass-through, 3x2
		write_reg(CFG_BLOCK_SIZE, 11'h7F0);
		write_reg(CFG_OUT_WIDTH, 11'd3);
		write_reg(CFG_OUT_HEIGHT, 11'd2);
		queue_random(8);
		wait_drained();

		// Mid-frame restart by a height write, then the unused index
		write_reg(CFG_OUT_HEIGHT, 11'd2);
		queue_random(4);
		wait_drained();
		write_reg(CFG_SPARE, 11'h5AA);
		queue_random(3);
		wait_drained();

		// Block size above the limit: one 8x8 block
		write_reg(CFG_BLOCK_SIZE, 11'h00F);
		write_reg(CFG_OUT_WIDTH, 11'd0);
		write_reg(CFG_OUT_HEIGHT, 11'd0);
		queue_random(64);
		wait_drained();

		// Width and height saturated, single pixel blocks, start of a row
		write_reg(CFG_BLOCK_SIZE, 11'd1);
		write_reg(CFG_OUT_WIDTH, 11'h7FF);
		write_reg(CFG_OUT_HEIGHT, 11'h7FF);
		queue_random(40);
		wait_drained();

		// Random phases: mostly whole frames, some partial ones
		rand_sent = 0;
		while (rand_sent < RAND_PIXELS) begin
			quiet_phase = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 9) == 0) write_reg(CFG_SPARE, CFG_DATA_W'($urandom));
			if ($urandom_range(0, 2) != 0) begin
				if ($urandom_range(0, 6) == 0)
					write_reg(CFG_BLOCK_SIZE, CFG_DATA_W'($urandom));
				else
					write_reg(CFG_BLOCK_SIZE, CFG_DATA_W'($urandom_range(1, 4)));
			end
			if ($urandom_range(0, 2) != 0) begin
				if ($urandom_range(0, 7) == 0)
					write_reg(CFG_OUT_WIDTH, CFG_DATA_W'($urandom));
				else
					write_reg(CFG_OUT_WIDTH, CFG_DATA_W'($urandom_range(0, 6)));
			end
			if ($urandom_range(0, 2) != 0) begin
				if ($urandom_range(0, 7) == 0)
					write_reg(CFG_OUT_HEIGHT, CFG_DATA_W'($urandom));
				else
					write_reg(CFG_OUT_HEIGHT, CFG_DATA_W'($urandom_range(0, 4)));
			end
			frame_px = eff_block() * eff_block() * eff_width() * eff_height();
			if (frame_px <= 256 && $urandom_range(0, 3) != 0)
				count = frame_px * $urandom_range(1, 2);
			else
				count = $urandom_range(1, 150);
			queue_random(count);
			rand_sent += count;
			wait_drained();
		end

		quiet_phase = 1'b0;
		wait_drained();
		repeat (20) @(posedge clk);
		if (errors == 0 && mean_q.size() == 0) begin
			$display("box_filter_downscale_top verification clean");
		end else begin
			$display("box_filter_downscale_top verification failed");
		end
		$finish;
	end

endmodule
